// ===== sv/tcth_pkg.sv =====
package tcth_pkg;

	// shared widths
	localparam int unsigned IN_W  = 20;
	localparam int unsigned C1_W  = 24;
	localparam int unsigned DVD_W = 53;
	localparam int unsigned DQ_W  = 32;
	localparam int unsigned V_W   = 28;

	// beta equation constants
	localparam logic [C1_W-1:0]  C1_Q16     = 24'd13543790;
	localparam int unsigned      BETA_INT   = 4350;
	localparam logic [IN_W-1:0]  R0_OHMS    = 20'd100000;
	localparam logic [DVD_W-1:0] DIVIDEND   = 53'(22'd2593905) << 31;
	localparam logic [V_W-1:0]   TK_LIMIT   = 28'd85010022;
	localparam logic [V_W-1:0]   V_BIAS     = 28'd49209754;
	localparam logic signed [16:0] Q_OFFSET = 17'sd16384;
	localparam logic signed [14:0] T_LOW    = -15'sd2048;
	localparam logic signed [14:0] T_HIGH   = 15'sd16383;
	localparam int unsigned      CLAMP_LO   = 5;

	// register map
	typedef enum logic [1:0] {
		REG_HEATER_FIXED = 2'd0,
		REG_BOX_FIXED    = 2'd1,
		REG_SETPOINT     = 2'd2
	} cfg_reg_t;

	// log2 unit sequencer
	typedef enum logic [1:0] {
		LOG_IDLE,
		LOG_NORM,
		LOG_SQR
	} log_state_t;

	// top level sequencer
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOG_FIX,
		ST_LOG_NUM,
		ST_LOG_DEN,
		ST_LOG_REF,
		ST_MUL_GO,
		ST_MUL,
		ST_D_CHK,
		ST_DIV,
		ST_Q_CALC,
		ST_FIN
	} seq_state_t;

endpackage

// ===== sv/thermistor_celsius_thermostat_top.sv =====
// NTC thermistor thermometer with a bang-bang heater decision.
// Input channel (in_valid/in_ready): one word holds a raw converter code and
// the sensor channel (0 heater, 1 box). Output channel (out_valid/out_ready):
// one word per input with the temperature in 1/16 degree C, the channel and
// the heater bit, which is set while the stored box temperature is at or
// below the setpoint. Configuration is a write-only port (cfg_we, cfg_index,
// cfg_data) for the two divider resistors and the setpoint.
// One word is converted at a time: four passes through the shared log2 unit
// (each normalizes its operand, squares once per fraction bit, then signals
// done), then the bit-serial multiplier and the bit-serial divider. The
// divider is skipped when the inverse temperature is negative or truncates
// to zero, and all units are skipped when the selected resistor is zero.
// in_ready comes back when the result has moved to the output register, so a
// new word is taken while the previous result still waits.
// A stalled receiver holds the output register and, once the next result is
// done, the sequencer waits with in_ready low.
// Reset restores the default resistors and setpoint and clears the stored box
// temperature to zero.
module thermistor_celsius_thermostat_top #(
	parameter int ADC_BITS      = 10,
	parameter int FRACTION_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ADC_BITS-1:0]             adc_code,
	input  logic                            sensor_channel,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [14:0]              temperature_q4,
	output logic                            channel_out,
	output logic                            heater_on,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [tcth_pkg::IN_W-1:0]       cfg_data
);

	localparam int LR_W = FRACTION_BITS + 5;
	localparam int LW   = FRACTION_BITS + 7;
	localparam int PW   = tcth_pkg::C1_W + LW;
	localparam int DW   = FRACTION_BITS + 33;
	localparam logic [ADC_BITS-1:0] ADC_MAX = '1;
	localparam logic [ADC_BITS-1:0] CLAMP_HI = ADC_MAX - ADC_BITS'(3);
	localparam logic signed [DW-1:0] B_CONST =
		DW'(tcth_pkg::BETA_INT) << (FRACTION_BITS + 16);

	tcth_pkg::seq_state_t state_q, state_d;

	logic [tcth_pkg::IN_W-1:0] heater_fixed_q;
	logic [tcth_pkg::IN_W-1:0] box_fixed_q;
	logic [7:0]                setpoint_q;
	logic signed [15:0]        box_temp_q;

	logic [ADC_BITS-1:0]       a_q;
	logic                      box_q;
	logic signed [LW-1:0]      lsum_q;
	logic                      neg_q;
	logic signed [DW-1:0]      d_q;
	logic signed [14:0]        res_q;

	logic                      out_valid_q;
	logic signed [14:0]        out_temp_q;
	logic                      out_chan_q;
	logic                      out_heat_q;

	logic                      accept;
	logic [ADC_BITS-1:0]       a_clamp;
	logic [tcth_pkg::IN_W-1:0] fixed_sel;
	logic [ADC_BITS-1:0]       num, den;
	logic                      log_start;
	logic [tcth_pkg::IN_W-1:0] log_x;
	logic                      log_done;
	logic [LR_W-1:0]           log_res;
	logic                      mul_start;
	logic                      mul_done;
	logic [PW-1:0]             prod;
	logic                      div_start;
	logic                      div_done;
	logic [tcth_pkg::DVD_W-1:0] tk;
	logic [tcth_pkg::DQ_W-1:0] dq;
	logic [tcth_pkg::V_W-1:0]  v;
	logic signed [16:0]        q_wide;
	logic signed [14:0]        q_sat;
	logic                      commit;
	logic signed [15:0]        box_next;

	assign accept = in_valid && in_ready;
	assign commit = (state_q == tcth_pkg::ST_FIN) && (!out_valid_q || out_ready);

	// clamp and divider orientation
	always_comb begin
		a_clamp = adc_code;
		if (adc_code < ADC_BITS'(tcth_pkg::CLAMP_LO)) a_clamp = ADC_BITS'(tcth_pkg::CLAMP_LO);
		if (adc_code > CLAMP_HI) a_clamp = CLAMP_HI;
	end
	assign fixed_sel = sensor_channel ? box_fixed_q : heater_fixed_q;
	assign num = box_q ? a_q : ADC_MAX - a_q;
	assign den = box_q ? ADC_MAX - a_q : a_q;

	// operand of the shared log2 unit
	always_comb begin
		case (state_q)
			tcth_pkg::ST_LOG_FIX: log_x = tcth_pkg::IN_W'(num);
			tcth_pkg::ST_LOG_NUM: log_x = tcth_pkg::IN_W'(den);
			tcth_pkg::ST_LOG_DEN: log_x = tcth_pkg::R0_OHMS;
			default:              log_x = fixed_sel;
		endcase
	end

	assign dq = d_q[FRACTION_BITS+tcth_pkg::DQ_W-1:FRACTION_BITS];

	// kelvin to celsius q4, round half up, saturate
	assign v      = tk[tcth_pkg::V_W-1:0] + tcth_pkg::V_BIAS;
	assign q_wide = $signed({1'b0, v[tcth_pkg::V_W-1:12]}) - tcth_pkg::Q_OFFSET;
	always_comb begin
		if (tk >= tcth_pkg::DVD_W'(tcth_pkg::TK_LIMIT)) q_sat = tcth_pkg::T_HIGH;
		else if (q_wide < 17'(tcth_pkg::T_LOW)) q_sat = tcth_pkg::T_LOW;
		else if (q_wide > 17'(tcth_pkg::T_HIGH)) q_sat = tcth_pkg::T_HIGH;
		else q_sat = q_wide[14:0];
	end

	// sequencer next state and unit starts
	always_comb begin
		state_d   = state_q;
		log_start = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		case (state_q)
			tcth_pkg::ST_IDLE: begin
				if (accept) begin
					if (fixed_sel == '0) begin
						state_d = tcth_pkg::ST_FIN;
					end else begin
						log_start = 1'b1;
						state_d   = tcth_pkg::ST_LOG_FIX;
					end
				end
			end
			tcth_pkg::ST_LOG_FIX: begin
				if (log_done) begin
					log_start = 1'b1;
					state_d   = tcth_pkg::ST_LOG_NUM;
				end
			end
			tcth_pkg::ST_LOG_NUM: begin
				if (log_done) begin
					log_start = 1'b1;
					state_d   = tcth_pkg::ST_LOG_DEN;
				end
			end
			tcth_pkg::ST_LOG_DEN: begin
				if (log_done) begin
					log_start = 1'b1;
					state_d   = tcth_pkg::ST_LOG_REF;
				end
			end
			tcth_pkg::ST_LOG_REF: begin
				if (log_done) state_d = tcth_pkg::ST_MUL_GO;
			end
			tcth_pkg::ST_MUL_GO: begin
				mul_start = 1'b1;
				state_d   = tcth_pkg::ST_MUL;
			end
			tcth_pkg::ST_MUL: begin
				if (mul_done) state_d = tcth_pkg::ST_D_CHK;
			end
			tcth_pkg::ST_D_CHK: begin
				if (d_q[DW-1] || dq == '0) begin
					state_d = tcth_pkg::ST_FIN;
				end else begin
					div_start = 1'b1;
					state_d   = tcth_pkg::ST_DIV;
				end
			end
			tcth_pkg::ST_DIV: begin
				if (div_done) state_d = tcth_pkg::ST_Q_CALC;
			end
			tcth_pkg::ST_Q_CALC: begin
				state_d = tcth_pkg::ST_FIN;
			end
			tcth_pkg::ST_FIN: begin
				if (commit) state_d = tcth_pkg::ST_IDLE;
			end
			default: state_d = tcth_pkg::ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == tcth_pkg::ST_IDLE);

	// state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= tcth_pkg::ST_IDLE;
			heater_fixed_q <= 20'd698;
			box_fixed_q    <= 20'd50300;
			setpoint_q     <= 8'd45;
			box_temp_q     <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					tcth_pkg::REG_HEATER_FIXED: heater_fixed_q <= cfg_data;
					tcth_pkg::REG_BOX_FIXED:    box_fixed_q    <= cfg_data;
					tcth_pkg::REG_SETPOINT:     setpoint_q     <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (commit) begin
				out_valid_q <= 1'b1;
				if (box_q) box_temp_q <= 16'(res_q);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			a_q   <= a_clamp;
			box_q <= sensor_channel;
			res_q <= tcth_pkg::T_LOW;
		end
		if (log_done) begin
			case (state_q)
				tcth_pkg::ST_LOG_FIX: lsum_q <= LW'(log_res);
				tcth_pkg::ST_LOG_NUM: lsum_q <= lsum_q + LW'(log_res);
				default:              lsum_q <= lsum_q - LW'(log_res);
			endcase
		end
		if (state_q == tcth_pkg::ST_MUL_GO) neg_q <= lsum_q[LW-1];
		if (state_q == tcth_pkg::ST_MUL && mul_done) begin
			if (neg_q) d_q <= B_CONST - DW'(prod);
			else d_q <= B_CONST + DW'(prod);
		end
		if (state_q == tcth_pkg::ST_D_CHK) begin
			if (d_q[DW-1]) res_q <= tcth_pkg::T_LOW;
			else res_q <= tcth_pkg::T_HIGH;
		end
		if (state_q == tcth_pkg::ST_Q_CALC) res_q <= q_sat;
		if (commit) begin
			out_temp_q <= res_q;
			out_chan_q <= box_q;
			out_heat_q <= (17'(box_next) <= $signed({5'b0, setpoint_q, 4'b0}));
		end
	end

	assign box_next = box_q ? 16'(res_q) : box_temp_q;

	// shared log2 unit
	tcth_log2 #(
		.FRAC_BITS(FRACTION_BITS)
	) u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.x      (log_x),
		.done   (log_done),
		.result (log_res)
	);

	// c1 times log sum, bit serial on the magnitude
	tcth_mul #(
		.A_W(tcth_pkg::C1_W),
		.B_W(LW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (tcth_pkg::C1_Q16),
		.b      (lsum_q[LW-1] ? LW'(-lsum_q) : LW'(lsum_q)),
		.done   (mul_done),
		.prod   (prod)
	);

	// reciprocal of inverse temperature
	tcth_div #(
		.N_W(tcth_pkg::DVD_W),
		.D_W(tcth_pkg::DQ_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (tcth_pkg::DIVIDEND),
		.divisor  (dq),
		.done     (div_done),
		.quotient (tk)
	);

	assign out_valid      = out_valid_q;
	assign temperature_q4 = out_temp_q;
	assign channel_out    = out_chan_q;
	assign heater_on      = out_heat_q;

endmodule

// ===== sv/tcth_log2.sv =====
module tcth_log2 #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tcth_pkg::IN_W-1:0]     x,
	output logic                          done,
	output logic [FRAC_BITS+4:0]          result
);

	localparam int CW = $clog2(FRAC_BITS + 1);

	tcth_pkg::log_state_t state_q, state_d;
	logic [30:0]          m_q;
	logic [4:0]           k_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [CW-1:0]        cnt_q;
	logic                 done_q;
	logic [61:0]          sq;
	logic [31:0]          sq_hi;
	logic                 last;

	// square of the mantissa, truncated back to q30
	assign sq    = 62'(m_q) * 62'(m_q);
	assign sq_hi = sq[61:30];
	assign last  = (cnt_q == CW'(FRAC_BITS - 1));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcth_pkg::LOG_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == tcth_pkg::LOG_SQR) && last && !start;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tcth_pkg::LOG_IDLE: begin
				if (start) state_d = tcth_pkg::LOG_NORM;
			end
			tcth_pkg::LOG_NORM: begin
				if (start) state_d = tcth_pkg::LOG_NORM;
				else if (m_q[30]) state_d = tcth_pkg::LOG_SQR;
			end
			tcth_pkg::LOG_SQR: begin
				if (start) state_d = tcth_pkg::LOG_NORM;
				else if (last) state_d = tcth_pkg::LOG_IDLE;
			end
			default: state_d = tcth_pkg::LOG_IDLE;
		endcase
	end

	// normalize one bit a cycle, then one fraction bit per square
	always_ff @(posedge clk) begin
		if (start) begin
			m_q   <= 31'(x);
			k_q   <= 5'd30;
			cnt_q <= '0;
		end else begin
			case (state_q)
				tcth_pkg::LOG_NORM: begin
					if (!m_q[30]) begin
						m_q <= {m_q[29:0], 1'b0};
						k_q <= k_q - 5'd1;
					end
				end
				tcth_pkg::LOG_SQR: begin
					if (sq_hi[31]) m_q <= sq_hi[31:1];
					else m_q <= sq_hi[30:0];
					frac_q <= {frac_q[FRAC_BITS-2:0], sq_hi[31]};
					cnt_q  <= cnt_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

	assign done   = done_q;
	assign result = {k_q, frac_q};

endmodule

// ===== sv/tcth_mul.sv =====
module tcth_mul #(
	parameter int A_W = 24,
	parameter int B_W = 23
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               done,
	output logic [A_W+B_W-1:0] prod
);

	localparam int CW = $clog2(B_W);

	logic               busy_q;
	logic               done_q;
	logic [CW-1:0]      cnt_q;
	logic [A_W-1:0]     a_q;
	logic [B_W-1:0]     b_q;
	logic [A_W+B_W-1:0] acc_q;
	logic               last;

	assign last = (cnt_q == CW'(B_W - 1));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && last && !start;
			if (start) busy_q <= 1'b1;
			else if (busy_q && last) busy_q <= 1'b0;
		end
	end

	// shift-add, multiplier bits msb first
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
			cnt_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[A_W+B_W-2:0], 1'b0} + (b_q[B_W-1] ? (A_W+B_W)'(a_q) : '0);
			b_q   <= {b_q[B_W-2:0], 1'b0};
			cnt_q <= cnt_q + CW'(1);
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ===== sv/tcth_div.sv =====
module tcth_div #(
	parameter int N_W = 53,
	parameter int D_W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N_W-1:0] quotient
);

	localparam int CW = $clog2(N_W);

	logic           busy_q;
	logic           done_q;
	logic [CW-1:0]  cnt_q;
	logic [N_W-1:0] dvd_q;
	logic [D_W-1:0] div_q;
	logic [D_W-1:0] rem_q;
	logic [D_W:0]   rem_sh;
	logic           fits;
	logic           last;

	// restoring step, one quotient bit a cycle
	assign rem_sh = {rem_q, dvd_q[N_W-1]};
	assign fits   = (rem_sh >= {1'b0, div_q});
	assign last   = (cnt_q == CW'(N_W - 1));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && last && !start;
			if (start) busy_q <= 1'b1;
			else if (busy_q && last) busy_q <= 1'b0;
		end
	end

	// dividend shifts out as quotient shifts in
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (fits) rem_q <= D_W'(rem_sh - {1'b0, div_q});
			else rem_q <= rem_sh[D_W-1:0];
			dvd_q <= {dvd_q[N_W-2:0], fits};
			cnt_q <= cnt_q + CW'(1);
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ===== sv/tcth_checker.sv =====
module tcth_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [14:0] temperature_q4,
	input logic               channel_out,
	input logic               heater_on
);

	// one word in flight: input closes right after a take
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// result never below the low saturation bound
	a_low_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temperature_q4 >= -15'sd2048)
		else $error("temperature below saturation bound");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(temperature_q4) && $stable(heater_on)
			&& $stable(channel_out))
		else $error("stalled result changed");

	// a box reading at or below zero is at or below any setpoint
	a_heater: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && channel_out && temperature_q4 <= 15'sd0 |-> heater_on)
		else $error("heater off for cold box");

endmodule

bind thermistor_celsius_thermostat_top tcth_checker u_tcth_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.temperature_q4 (temperature_q4),
	.channel_out    (channel_out),
	.heater_on      (heater_on)
);
